FILE: hw/rtl/elr_pkg.sv
package elr_pkg;

	// field widths
	localparam int CUR_W   = 16;
	localparam int VOLT_W  = 16;
	localparam int DES_W   = 15;
	localparam int ACC_W   = 24;
	localparam int CFG_W   = 20;
	localparam int IDX_W   = 4;
	localparam int GAIN_W  = 8;
	localparam int TOL_W   = 12;
	localparam int STEP_W  = 10;
	localparam int POW_W   = 20;
	localparam int RES_W   = 20;

	// shared divider, one quotient bit per step
	localparam int DIV_W     = 20;
	localparam int DIV_STEPS = DIV_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	// limits
	localparam int OFFSET_MIN  = -2048;
	localparam int OFFSET_MAX  = 2047;
	localparam int CURRENT_MIN = 0;
	localparam int CURRENT_MAX = 32767;

	// operating modes
	localparam logic [2:0] MODE_OFF = 3'd0;
	localparam logic [2:0] MODE_CC  = 3'd1;
	localparam logic [2:0] MODE_CP  = 3'd2;
	localparam logic [2:0] MODE_CR  = 3'd3;
	localparam logic [2:0] MODE_CV  = 3'd4;

	// register indexes
	localparam logic [IDX_W-1:0] REG_MODE     = 4'd0;
	localparam logic [IDX_W-1:0] REG_TGT_CUR  = 4'd1;
	localparam logic [IDX_W-1:0] REG_TGT_POW  = 4'd2;
	localparam logic [IDX_W-1:0] REG_TGT_RES  = 4'd3;
	localparam logic [IDX_W-1:0] REG_TGT_VOLT = 4'd4;
	localparam logic [IDX_W-1:0] REG_GAIN     = 4'd5;
	localparam logic [IDX_W-1:0] REG_TOL      = 4'd6;
	localparam logic [IDX_W-1:0] REG_STEP     = 4'd7;

	// action codes
	localparam logic ACT_CURRENT = 1'b0;
	localparam logic ACT_VOLTAGE = 1'b1;

	typedef struct packed {
		logic capture;
		logic mul;
		logic acc;
		logic div_step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic div_mode;
	} status_t;

endpackage

FILE: hw/rtl/elr_if.sv
interface elr_sample_if;
	import elr_pkg::*;
	logic                     valid;
	logic                     ready;
	logic                     action;
	logic signed [CUR_W-1:0]  sample_current_ma;
	logic [VOLT_W-1:0]        sample_voltage_mv;

	modport source (output valid, output action, output sample_current_ma,
		output sample_voltage_mv, input ready);
	modport sink (input valid, input action, input sample_current_ma,
		input sample_voltage_mv, output ready);
endinterface

interface elr_result_if;
	import elr_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [CUR_W-1:0]  drive_current_ma;
	logic                     zero_output;
	logic [DES_W-1:0]         desired_ma;

	modport source (output valid, output drive_current_ma, output zero_output,
		output desired_ma, input ready);
	modport sink (input valid, input drive_current_ma, input zero_output,
		input desired_ma, output ready);
endinterface

FILE: hw/rtl/elr_ctrl.sv
module elr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_action,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	input  elr_pkg::status_t status,
	output elr_pkg::cmd_t    cmd
);
	import elr_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_ACC  = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               out_valid_q;
	logic               accept;
	logic               can_load;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign can_load  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// datapath commands
	always_comb begin
		cmd          = '0;
		cmd.capture  = accept;
		cmd.mul      = (state_q == ST_MUL);
		cmd.acc      = (state_q == ST_ACC);
		cmd.div_step = (state_q == ST_DIV);
		cmd.finish   = (state_q == ST_FIN) && can_load;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (accept) begin
						if (in_action == ACT_CURRENT)
							state_q <= ST_MUL;
						else if (status.div_mode)
							state_q <= ST_DIV;
						else
							state_q <= ST_FIN;
					end
				end
				ST_MUL: state_q <= ST_ACC;
				ST_ACC: state_q <= ST_IDLE;
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIV_STEPS - 1))
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (can_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result valid flag, held until transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: hw/rtl/elr_datapath.sv
module elr_datapath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [elr_pkg::IDX_W-1:0]     cfg_index,
	input  logic [elr_pkg::CFG_W-1:0]     cfg_data,
	input  logic signed [elr_pkg::CUR_W-1:0] sample_current_ma,
	input  logic [elr_pkg::VOLT_W-1:0]    sample_voltage_mv,
	input  elr_pkg::cmd_t                 cmd,
	output elr_pkg::status_t              status,
	output logic signed [elr_pkg::CUR_W-1:0] drive_current_ma,
	output logic                          zero_output,
	output logic [elr_pkg::DES_W-1:0]     desired_ma
);
	import elr_pkg::*;

	localparam logic signed [27:0] ACC_LO = 28'(OFFSET_MIN * 256);
	localparam logic signed [27:0] ACC_HI = 28'(OFFSET_MAX * 256);
	localparam logic signed [16:0] DES_LO = 17'(CURRENT_MIN);
	localparam logic signed [16:0] DES_HI = 17'(CURRENT_MAX);
	localparam logic [DES_W-1:0]   DES_MAX = DES_W'(CURRENT_MAX);
	localparam logic signed [16:0] DRV_LO = -17'sd32768;
	localparam logic signed [16:0] DRV_HI = 17'sd32767;

	// configuration registers
	logic [2:0]          mode_q;
	logic [DES_W-1:0]    tgt_cur_q;
	logic [POW_W-1:0]    tgt_pow_q;
	logic [RES_W-1:0]    tgt_res_q;
	logic [VOLT_W-1:0]   tgt_volt_q;
	logic [GAIN_W-1:0]   gain_q;
	logic [TOL_W-1:0]    tol_q;
	logic [STEP_W-1:0]   step_q;

	// regulator state
	logic [DES_W-1:0]        desired_q;
	logic signed [ACC_W-1:0] acc_q;

	// sample and working registers
	logic signed [CUR_W-1:0] meas_q;
	logic [VOLT_W-1:0]       volt_q;
	logic signed [26:0]      prod_s1;
	logic [DIV_W-1:0]        quo_q;
	logic [DIV_W-1:0]        rem_q;
	logic [DIV_W-1:0]        dsr_q;

	// result register
	logic signed [CUR_W-1:0] drive_q;
	logic                    zero_q;
	logic [DES_W-1:0]        des_out_q;

	logic signed [17:0]  err;
	logic signed [27:0]  acc_sum;
	logic signed [ACC_W-1:0] acc_next;
	logic [DIV_W:0]      rem_shift;
	logic                rem_ge;
	logic [16:0]         cv_upper;
	logic signed [17:0]  cv_lower;
	logic signed [16:0]  cv_raw;
	logic [DES_W-1:0]    cv_d;
	logic [DES_W-1:0]    quo_sat;
	logic [DES_W-1:0]    new_d;
	logic signed [CUR_W-1:0] whole;
	logic signed [16:0]  drv_sum;
	logic signed [CUR_W-1:0] drv_sat;

	assign status.div_mode = (mode_q inside {MODE_CP, MODE_CR});

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= MODE_OFF;
			tgt_cur_q  <= '0;
			tgt_pow_q  <= '0;
			tgt_res_q  <= RES_W'(1000);
			tgt_volt_q <= '0;
			gain_q     <= GAIN_W'(16);
			tol_q      <= TOL_W'(10);
			step_q     <= STEP_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:     mode_q     <= cfg_data[2:0];
				REG_TGT_CUR:  tgt_cur_q  <= cfg_data[DES_W-1:0];
				REG_TGT_POW:  tgt_pow_q  <= cfg_data[POW_W-1:0];
				REG_TGT_RES:  tgt_res_q  <= cfg_data[RES_W-1:0];
				REG_TGT_VOLT: tgt_volt_q <= cfg_data[VOLT_W-1:0];
				REG_GAIN:     gain_q     <= cfg_data[GAIN_W-1:0];
				REG_TOL:      tol_q      <= cfg_data[TOL_W-1:0];
				REG_STEP:     step_q     <= cfg_data[STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// integrator: error times gain, then add and clamp
	assign err = $signed({3'b000, desired_q}) - $signed({{2{meas_q[CUR_W-1]}}, meas_q});
	assign acc_sum = $signed({{4{acc_q[ACC_W-1]}}, acc_q})
		+ $signed({prod_s1[26], prod_s1});

	always_comb begin
		if (acc_sum < ACC_LO)
			acc_next = ACC_W'(ACC_LO);
		else if (acc_sum > ACC_HI)
			acc_next = ACC_W'(ACC_HI);
		else
			acc_next = acc_sum[ACC_W-1:0];
	end

	// restoring divider step
	assign rem_shift = {rem_q, quo_q[DIV_W-1]};
	assign rem_ge    = (rem_shift >= {1'b0, dsr_q});

	// constant voltage stepping
	assign cv_upper = {1'b0, tgt_volt_q} + {5'b00000, tol_q};
	assign cv_lower = $signed({2'b00, tgt_volt_q}) - $signed({6'b000000, tol_q});

	always_comb begin
		if ({1'b0, volt_q} > cv_upper)
			cv_raw = $signed({2'b00, desired_q}) + $signed({7'b0000000, step_q});
		else if ($signed({2'b00, volt_q}) < cv_lower)
			cv_raw = $signed({2'b00, desired_q}) - $signed({7'b0000000, step_q});
		else
			cv_raw = $signed({2'b00, desired_q});
		if (cv_raw < DES_LO)
			cv_d = DES_W'(DES_LO);
		else if (cv_raw > DES_HI)
			cv_d = DES_W'(DES_HI);
		else
			cv_d = cv_raw[DES_W-1:0];
	end

	// saturated quotient, zero divisor gives full scale
	always_comb begin
		if (dsr_q == '0 || quo_q > DIV_W'(CURRENT_MAX))
			quo_sat = DES_MAX;
		else
			quo_sat = quo_q[DES_W-1:0];
	end

	// desired level by mode
	always_comb begin
		case (mode_q)
			MODE_CC: new_d = tgt_cur_q;
			MODE_CP: new_d = quo_sat;
			MODE_CR: new_d = quo_sat;
			MODE_CV: new_d = cv_d;
			default: new_d = '0;
		endcase
	end

	// drive level: desired plus whole part of the offset
	assign whole   = acc_q[ACC_W-1:8];
	assign drv_sum = $signed({2'b00, new_d}) + $signed({whole[CUR_W-1], whole});

	always_comb begin
		if (drv_sum > DRV_HI)
			drv_sat = CUR_W'(DRV_HI);
		else if (drv_sum < DRV_LO)
			drv_sat = CUR_W'(DRV_LO);
		else
			drv_sat = drv_sum[CUR_W-1:0];
	end

	// regulator state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desired_q <= '0;
			acc_q     <= '0;
		end else if (cmd.acc) begin
			acc_q <= acc_next;
		end else if (cmd.finish) begin
			desired_q <= new_d;
			if (new_d == '0)
				acc_q <= '0;
		end
	end

	// sample capture, multiplier and divider registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			meas_q <= sample_current_ma;
			volt_q <= sample_voltage_mv;
			rem_q  <= '0;
			if (mode_q == MODE_CP) begin
				quo_q <= tgt_pow_q;
				dsr_q <= {{(DIV_W-VOLT_W){1'b0}}, sample_voltage_mv};
			end else begin
				quo_q <= {{(DIV_W-VOLT_W){1'b0}}, sample_voltage_mv};
				dsr_q <= tgt_res_q;
			end
		end else if (cmd.div_step) begin
			rem_q <= rem_ge ? DIV_W'(rem_shift - {1'b0, dsr_q}) : rem_shift[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], rem_ge};
		end
		if (cmd.mul)
			prod_s1 <= 27'(err) * 27'($signed({1'b0, gain_q}));
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			des_out_q <= new_d;
			zero_q    <= (new_d == '0);
			drive_q   <= (new_d == '0) ? '0 : drv_sat;
		end
	end

	assign drive_current_ma = drive_q;
	assign zero_output      = zero_q;
	assign desired_ma       = des_out_q;

endmodule

FILE: hw/rtl/electronic_load_current_regulator.sv
// Electronic load current regulator.
// The sample channel takes measurement items: action 0 carries a measured
// current that feeds the offset integrator and gives no result; action 1
// carries a measured voltage that sets the desired current by the mode and
// gives one item on the result channel (drive current, zero flag, desired).
// Configuration is a plain write port (cfg_we, cfg_index, cfg_data), to be
// used while the block is idle, which the block itself does not enforce;
// indexes beyond the register list are ignored. A current sample keeps the
// block busy through the multiply state, then the add and clamp state. A
// voltage sample in constant power or constant resistance mode first runs
// the shared restoring divider, one quotient bit per step; in the other
// modes it goes straight to the finish state, which loads the result.
// One item is worked on at a time; the next sample is taken as soon as the
// block returns to idle, even while a result waits in the output register.
// If the receiver stalls, a finished result holds and the next voltage result
// waits for the transfer. Reset clears the desired level, the offset and the
// result valid flag and loads the register reset values.
module electronic_load_current_regulator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [elr_pkg::IDX_W-1:0]     cfg_index,
	input  logic [elr_pkg::CFG_W-1:0]     cfg_data,
	elr_sample_if.sink                    sample,
	elr_result_if.source                  result
);
	import elr_pkg::*;

	cmd_t    cmd;
	status_t status;

	elr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample.valid),
		.in_action (sample.action),
		.in_ready  (sample.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	elr_datapath u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_we            (cfg_we),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.sample_current_ma (sample.sample_current_ma),
		.sample_voltage_mv (sample.sample_voltage_mv),
		.cmd               (cmd),
		.status            (status),
		.drive_current_ma  (result.drive_current_ma),
		.zero_output       (result.zero_output),
		.desired_ma        (result.desired_ma)
	);

endmodule

FILE: hw/rtl/elr_checker.sv
module elr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_action,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] drive_current_ma,
	input logic        zero_output,
	input logic [14:0] desired_ma
);

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(drive_current_ma)
			&& $stable(zero_output) && $stable(desired_ma))
		else $error("result changed while stalled");

	// zero flag goes with zero drive and zero desired
	a_zero_drive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zero_output |-> drive_current_ma == 16'd0 && desired_ma == 15'd0)
		else $error("zero flag with nonzero drive or desired");

	// a result without the zero flag has a nonzero desired level
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !zero_output |-> desired_ma != 15'd0)
		else $error("zero desired without zero flag");

	// a current sample makes no result
	a_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_action && !out_valid |=> !out_valid)
		else $error("result after current sample");

endmodule

bind electronic_load_current_regulator elr_checker u_elr_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.in_valid         (sample.valid),
	.in_ready         (sample.ready),
	.in_action        (sample.action),
	.out_valid        (result.valid),
	.out_ready        (result.ready),
	.drive_current_ma (result.drive_current_ma),
	.zero_output      (result.zero_output),
	.desired_ma       (result.desired_ma)
);

FILE: bench/electronic_load_current_regulator_test.sv
module electronic_load_current_regulator_test;
	import elr_pkg::*;

	localparam int PHASES          = 14;
	localparam int ITEMS_PER_PHASE = 131;
	localparam int DRAIN_CYCLES    = 30;
	localparam int IDLE_PCT        = 22;
	localparam logic [IDX_W-1:0] REG_UNUSED = 4'd15;

	typedef struct packed {
		logic signed [CUR_W-1:0] drive;
		logic                    zero;
		logic [DES_W-1:0]        desired;
	} drive_t;

	typedef struct {
		bit                      is_cfg;
		logic [IDX_W-1:0]        idx;
		logic [CFG_W-1:0]        val;
		logic                    act;
		logic signed [CUR_W-1:0] cur;
		logic [VOLT_W-1:0]       volt;
		bit                      typed;
		drive_t                  want;
	} plan_row_t;

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	elr_sample_if sample_ch ();
	elr_result_if result_ch ();

	electronic_load_current_regulator uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.sample   (sample_ch),
		.result   (result_ch)
	);

	// regulator image: registers and state
	logic [2:0]       mode_r;
	logic [DES_W-1:0] tgt_cur;
	logic [POW_W-1:0] tgt_pow;
	logic [RES_W-1:0] tgt_res;
	logic [VOLT_W-1:0] tgt_volt;
	logic [GAIN_W-1:0] gain;
	logic [TOL_W-1:0]  tol;
	logic [STEP_W-1:0] step_ma;
	longint desired_lvl;
	longint offset_acc;

	drive_t    expected_q[$];
	plan_row_t plan[$];
	int        errors = 0;
	bit        steady;

	// clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop if the run hangs
	initial begin
		#20000000;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic longint clamp(input longint x, input longint lo, input longint hi);
		if (x < lo) return lo;
		if (x > hi) return hi;
		return x;
	endfunction

	function automatic void load_defaults();
		mode_r      = MODE_OFF;
		tgt_cur     = '0;
		tgt_pow     = '0;
		tgt_res     = RES_W'(1000);
		tgt_volt    = '0;
		gain        = GAIN_W'(16);
		tol         = TOL_W'(10);
		step_ma     = STEP_W'(1);
		desired_lvl = 0;
		offset_acc  = 0;
	endfunction

	// one sample through the regulator image; returns 1 when a result is due
	function automatic bit regulate(input logic act, input logic signed [CUR_W-1:0] cur,
			input logic [VOLT_W-1:0] volt, output drive_t res);
		longint v;
		longint d;
		v = longint'(volt);
		res = '0;
		if (act == ACT_CURRENT) begin
			offset_acc = clamp(offset_acc + (desired_lvl - longint'(cur)) * longint'(gain),
				longint'(OFFSET_MIN) * 256, longint'(OFFSET_MAX) * 256);
			return 1'b0;
		end
		case (mode_r)
			MODE_CC: d = longint'(tgt_cur);
			MODE_CP: d = (v == 0) ? longint'(CURRENT_MAX) : longint'(tgt_pow) / v;
			MODE_CR: d = (tgt_res == 0) ? longint'(CURRENT_MAX) : v / longint'(tgt_res);
			MODE_CV: begin
				d = desired_lvl;
				// dead band compare is signed, the low edge may go negative
				if (v > longint'(tgt_volt) + longint'(tol))
					d = d + longint'(step_ma);
				else if (v < longint'(tgt_volt) - longint'(tol))
					d = d - longint'(step_ma);
			end
			default: d = 0;
		endcase
		desired_lvl = clamp(d, longint'(CURRENT_MIN), longint'(CURRENT_MAX));
		if (desired_lvl == 0) begin
			offset_acc = 0;
			res.zero = 1'b1;
		end else begin
			res.drive = CUR_W'(clamp(desired_lvl + (offset_acc >>> 8), -32768, 32767));
		end
		res.desired = desired_lvl[DES_W-1:0];
		return 1'b1;
	endfunction

	// directed plan rows
	function automatic void cfg_row(input logic [IDX_W-1:0] idx, input longint val);
		plan_row_t r;
		r = '{default: '0};
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.val = CFG_W'(val);
		plan.push_back(r);
	endfunction

	function automatic void stim(input logic act, input logic signed [CUR_W-1:0] cur,
			input logic [VOLT_W-1:0] volt);
		plan_row_t r;
		r = '{default: '0};
		r.act = act;
		r.cur = cur;
		r.volt = volt;
		plan.push_back(r);
	endfunction

	function automatic void stim_exp(input logic [VOLT_W-1:0] volt,
			input logic signed [CUR_W-1:0] drive, input logic zero, input logic [DES_W-1:0] des);
		plan_row_t r;
		r = '{default: '0};
		r.act = ACT_VOLTAGE;
		r.volt = volt;
		r.typed = 1'b1;
		r.want.drive = drive;
		r.want.zero = zero;
		r.want.desired = des;
		plan.push_back(r);
	endfunction

	// range end or random value inside it
	function automatic longint pick(input longint lo, input longint hi, input int ext);
		if (ext == 0) return lo;
		if (ext == 1) return hi;
		return lo + longint'($urandom_range(0, int'(hi - lo)));
	endfunction

	// let the block go quiet before touching registers
	task automatic drain();
		sample_ch.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic put_reg(input logic [IDX_W-1:0] idx, input longint val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_W'(val);
		@(posedge clk);
		case (idx)
			REG_MODE:     mode_r   = val[2:0];
			REG_TGT_CUR:  tgt_cur  = val[DES_W-1:0];
			REG_TGT_POW:  tgt_pow  = val[POW_W-1:0];
			REG_TGT_RES:  tgt_res  = val[RES_W-1:0];
			REG_TGT_VOLT: tgt_volt = val[VOLT_W-1:0];
			REG_GAIN:     gain     = val[GAIN_W-1:0];
			REG_TOL:      tol      = val[TOL_W-1:0];
			REG_STEP:     step_ma  = val[STEP_W-1:0];
			default: ;
		endcase
	endtask

	// one sample transfer, with random idle cycles ahead of it
	task automatic send(input logic act, input logic signed [CUR_W-1:0] cur,
			input logic [VOLT_W-1:0] volt, input bit typed, input drive_t want);
		drive_t got;
		cfg_we <= 1'b0;
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid             <= 1'b1;
		sample_ch.action            <= act;
		sample_ch.sample_current_ma <= cur;
		sample_ch.sample_voltage_mv <= volt;
		do @(posedge clk); while (!sample_ch.ready);
		if (regulate(act, cur, volt, got))
			expected_q.push_back(typed ? want : got);
	endtask

	// result side backpressure
	always @(posedge clk) begin
		result_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		drive_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_q.size() == 0) begin
				$error("result transfer with nothing expected, drive_current_ma %0d",
					result_ch.drive_current_ma);
				errors++;
			end else begin
				want = expected_q.pop_front();
				if (result_ch.drive_current_ma !== want.drive) begin
					$error("drive_current_ma expected %0d got %0d", want.drive,
						result_ch.drive_current_ma);
					errors++;
				end
				if (result_ch.zero_output !== want.zero) begin
					$error("zero_output expected %0d got %0d", want.zero, result_ch.zero_output);
					errors++;
				end
				if (result_ch.desired_ma !== want.desired) begin
					$error("desired_ma expected %0d got %0d", want.desired, result_ch.desired_ma);
					errors++;
				end
			end
		end
	end

	initial begin
		bit                      in_cfg;
		int                      ext;
		int                      m;
		logic                    act;
		logic signed [CUR_W-1:0] cur;
		logic [VOLT_W-1:0]       volt;
		longint                  band;

		steady = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_MODE;
		cfg_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.action = ACT_CURRENT;
		sample_ch.sample_current_ma = '0;
		sample_ch.sample_voltage_mv = '0;
		load_defaults();

		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// off mode after reset, integrator pinned at its top
		stim_exp(16'd0, 16'sd0, 1'b1, 15'd0);
		stim(ACT_CURRENT, -16'sd32768, 16'd0);
		stim_exp(16'hFFFF, 16'sd0, 1'b1, 15'd0);
		// constant current at full scale, offset swings from near its bottom to its top
		cfg_row(REG_MODE, MODE_CC);
		cfg_row(REG_TGT_CUR, CURRENT_MAX);
		stim(ACT_CURRENT, 16'sd32767, 16'd0);
		stim(ACT_VOLTAGE, 16'sd0, 16'd1000);
		stim(ACT_CURRENT, -16'sd32768, 16'd0);
		stim_exp(16'd0, 16'sd32767, 1'b0, 15'd32767);
		cfg_row(REG_GAIN, 8'hFF);
		stim(ACT_CURRENT, 16'sd32767, 16'd0);
		// zero set point clears the offset
		cfg_row(REG_TGT_CUR, 0);
		stim_exp(16'd1, 16'sd0, 1'b1, 15'd0);
		// constant power: zero voltage, small quotient, saturated quotient, zero power
		cfg_row(REG_MODE, MODE_CP);
		cfg_row(REG_TGT_POW, 20'hFFFFF);
		stim_exp(16'd0, 16'sd32767, 1'b0, 15'd32767);
		stim(ACT_VOLTAGE, 16'sd0, 16'hFFFF);
		stim(ACT_VOLTAGE, 16'sd0, 16'd31);
		cfg_row(REG_TGT_POW, 0);
		stim_exp(16'd500, 16'sd0, 1'b1, 15'd0);
		// constant resistance: zero resistance, one, largest, typical
		cfg_row(REG_MODE, MODE_CR);
		cfg_row(REG_TGT_RES, 0);
		stim_exp(16'd1234, 16'sd32767, 1'b0, 15'd32767);
		cfg_row(REG_TGT_RES, 1);
		stim(ACT_VOLTAGE, 16'sd0, 16'hFFFF);
		cfg_row(REG_TGT_RES, 20'hFFFFF);
		stim_exp(16'hFFFF, 16'sd0, 1'b1, 15'd0);
		cfg_row(REG_TGT_RES, 1000);
		stim(ACT_VOLTAGE, 16'sd0, 16'd5000);
		// constant voltage: step up, hold, negative band edge, step down, floor
		cfg_row(REG_MODE, MODE_CV);
		cfg_row(REG_TGT_VOLT, 0);
		cfg_row(REG_TOL, 0);
		cfg_row(REG_STEP, 10'h3FF);
		cfg_row(REG_GAIN, 0);
		stim(ACT_VOLTAGE, 16'sd0, 16'd1);
		stim(ACT_CURRENT, -16'sd1, 16'd0);
		stim(ACT_VOLTAGE, 16'sd0, 16'd0);
		cfg_row(REG_TOL, 12'hFFF);
		stim(ACT_VOLTAGE, 16'sd0, 16'd0);
		cfg_row(REG_TGT_VOLT, 16'hFFFF);
		stim(ACT_VOLTAGE, 16'sd0, 16'd0);
		stim_exp(16'd0, 16'sd0, 1'b1, 15'd0);
		// unused mode code acts as off, unused index is dropped
		cfg_row(REG_MODE, 3'd7);
		cfg_row(REG_UNUSED, 20'hFFFFF);
		stim_exp(16'd40000, 16'sd0, 1'b1, 15'd0);

		in_cfg = 1'b0;
		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				if (!in_cfg) drain();
				put_reg(plan[i].idx, longint'(plan[i].val));
			end else begin
				send(plan[i].act, plan[i].cur, plan[i].volt, plan[i].typed, plan[i].want);
			end
			in_cfg = plan[i].is_cfg;
		end

		// random phases, each with its own register setting
		for (int phase = 0; phase < PHASES; phase++) begin
			ext = phase % 3;
			m = phase % 7;
			steady = (phase == 6 || phase == 7);
			drain();
			if (m < 5)
				put_reg(REG_MODE, longint'(m));
			else if (m == 5)
				put_reg(REG_MODE, MODE_CV);
			else
				put_reg(REG_MODE, longint'($urandom_range(5, 7)));
			put_reg(REG_TGT_CUR, pick(0, CURRENT_MAX, ext));
			put_reg(REG_TGT_POW, pick(0, (1 << POW_W) - 1, ext));
			if (ext == 2 && $urandom_range(0, 3) != 0)
				put_reg(REG_TGT_RES, longint'($urandom_range(1, 200)));
			else
				put_reg(REG_TGT_RES, pick(1, (1 << RES_W) - 1, ext));
			put_reg(REG_TGT_VOLT, pick(0, (1 << VOLT_W) - 1, ext));
			put_reg(REG_GAIN, pick(0, (1 << GAIN_W) - 1, ext));
			put_reg(REG_TOL, pick(0, (1 << TOL_W) - 1, ext));
			put_reg(REG_STEP, pick(0, (1 << STEP_W) - 1, ext));

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				cur = CUR_W'($urandom());
				volt = VOLT_W'($urandom());
				if ($urandom_range(0, 99) < 40) begin
					act = ACT_CURRENT;
					// mostly near the set point so the integrator moves both ways
					if ($urandom_range(0, 9) < 7)
						cur = CUR_W'(clamp(desired_lvl + longint'($urandom_range(0, 400)) - 200,
							-32768, 32767));
				end else begin
					act = ACT_VOLTAGE;
					if (mode_r == MODE_CV && $urandom_range(0, 9) < 7) begin
						band = longint'(tol) + 20;
						volt = VOLT_W'(clamp(longint'(tgt_volt)
							+ longint'($urandom_range(0, int'(2 * band))) - band, 0, 65535));
					end else if (mode_r == MODE_CP && $urandom_range(0, 1) == 0) begin
						volt = VOLT_W'($urandom_range(0, 64));
					end
				end
				send(act, cur, volt, 1'b0, '0);
			end
		end

		drain();
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
hw/rtl/elr_pkg.sv
hw/rtl/elr_if.sv
hw/rtl/elr_ctrl.sv
hw/rtl/elr_datapath.sv
hw/rtl/electronic_load_current_regulator.sv
hw/rtl/elr_checker.sv
bench/electronic_load_current_regulator_test.sv
